// File: rtl/dcds_pkg.sv
`timescale 1ns / 1ps

package dcds_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 32;
    localparam int DIST_W  = 33;
    localparam int IDX_W   = 6;
    localparam int CFG_A_W = 2;

    localparam logic [CFG_A_W-1:0] REG_CAMERA_X    = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_CAMERA_Z    = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_MAX_DIST_SQ = 2'd2;

    localparam logic [DIST_W-1:0] MAX_DIST_RESET = 33'd40960000;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_START = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dsq;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ADD,
        ST_CHECK,
        ST_SHIFT,
        ST_PLACE,
        ST_EMIT,
        ST_EMPTY
    } state_t;

endpackage

// File: rtl/distance_cull_depth_sort.sv
`timescale 1ns / 1ps

// Distance cull and far-to-near depth sort. Load requests (tuser 0) carry a
// center point; its squared distance to the camera is formed in registered
// steps (difference, squares, sum) and then checked against max_dist_sq. A
// kept point is inserted into a sorted list held in one memory with a single
// read and a single write port: the insertion walks up from the nearest entry,
// moving one entry a cycle, until it meets an entry that is not nearer.
// Once MAX_OBJECTS points are loaded in a frame further loads are taken and
// ignored. A start request (tuser 1) first reads the list memory, then emits
// the list in order, one result a cycle while the output is taken; equal
// distances come out in load order. With nothing kept a start gives one
// result with tuser (empty) and tlast high. The start ends the frame.
// Configuration is written through cfg_wr_en / cfg_addr / cfg_wr_data.
module distance_cull_depth_sort #(
    parameter int MAX_OBJECTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [32:0] cfg_wr_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pos_x [15:0], pos_z [31:16]
    input  logic        s_axis_tuser,   // action [0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // object_index [5:0], distance_sq [38:6], zero [39]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // is_empty [0]
);

    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CW = $clog2(MAX_OBJECTS + 1);

    // configuration
    logic signed [dcds_pkg::COORD_W-1:0] cam_x_reg;
    logic signed [dcds_pkg::COORD_W-1:0] cam_z_reg;
    logic [dcds_pkg::DIST_W-1:0]         max_dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg    <= '0;
            cam_z_reg    <= '0;
            max_dist_reg <= dcds_pkg::MAX_DIST_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dcds_pkg::REG_CAMERA_X:    cam_x_reg    <= cfg_wr_data[dcds_pkg::COORD_W-1:0];
                dcds_pkg::REG_CAMERA_Z:    cam_z_reg    <= cfg_wr_data[dcds_pkg::COORD_W-1:0];
                dcds_pkg::REG_MAX_DIST_SQ: max_dist_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // sorted list memory
    dcds_pkg::entry_t mem [MAX_OBJECTS];
    dcds_pkg::entry_t rd_data;
    dcds_pkg::entry_t wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    // control and datapath registers
    dcds_pkg::state_t state_reg, state_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [CW-1:0] load_cnt_reg, load_cnt_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] eptr_reg, eptr_next;
    logic signed [dcds_pkg::DIFF_W-1:0] dx_reg, dx_next, dz_reg, dz_next;
    logic [dcds_pkg::SQ_W-1:0]   sqx_reg, sqx_next, sqz_reg, sqz_next;
    logic [dcds_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic [dcds_pkg::IDX_W-1:0]  tag_reg, tag_next;
    logic                        out_valid_reg, out_valid_next;
    dcds_pkg::entry_t            out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_empty_reg, out_empty_next;

    logic signed [2*dcds_pkg::DIFF_W-1:0] prod_x, prod_z;
    logic out_free;
    logic in_req;
    logic emit_last;

    function automatic logic signed [dcds_pkg::DIFF_W-1:0] DIFF_EXT(
        input logic [dcds_pkg::COORD_W-1:0] v
    );
        DIFF_EXT = {v[dcds_pkg::COORD_W-1], v};
    endfunction

    assign out_free = !out_valid_reg || m_axis_tready;
    assign in_req   = s_axis_tvalid && (state_reg == dcds_pkg::ST_IDLE);
    assign prod_x   = dx_reg * dx_reg;
    assign prod_z   = dz_reg * dz_reg;
    assign emit_last = (CW'(eptr_reg) + CW'(1)) == kept_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dcds_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == dcds_pkg::ACT_START) begin
                        state_next = (kept_reg == '0) ? dcds_pkg::ST_EMPTY
                                                      : dcds_pkg::ST_EMIT;
                    end else if (load_cnt_reg < CW'(MAX_OBJECTS)) begin
                        state_next = dcds_pkg::ST_SQUARE;
                    end
                end
            end
            dcds_pkg::ST_SQUARE: state_next = dcds_pkg::ST_ADD;
            dcds_pkg::ST_ADD:    state_next = dcds_pkg::ST_CHECK;
            dcds_pkg::ST_CHECK: begin
                if (dist_reg <= max_dist_reg && kept_reg < CW'(MAX_OBJECTS)) begin
                    state_next = (kept_reg == '0) ? dcds_pkg::ST_PLACE
                                                  : dcds_pkg::ST_SHIFT;
                end else begin
                    state_next = dcds_pkg::ST_IDLE;
                end
            end
            dcds_pkg::ST_SHIFT: begin
                if (!(rd_data.dsq < dist_reg) || ptr_reg == CW'(1)) begin
                    state_next = dcds_pkg::ST_PLACE;
                end
            end
            dcds_pkg::ST_PLACE: state_next = dcds_pkg::ST_IDLE;
            dcds_pkg::ST_EMIT: begin
                if (out_free && emit_last) begin
                    state_next = dcds_pkg::ST_IDLE;
                end
            end
            dcds_pkg::ST_EMPTY: begin
                if (out_free) begin
                    state_next = dcds_pkg::ST_IDLE;
                end
            end
            default: state_next = dcds_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        kept_next      = kept_reg;
        load_cnt_next  = load_cnt_reg;
        ptr_next       = ptr_reg;
        eptr_next      = eptr_reg;
        dx_next        = dx_reg;
        dz_next        = dz_reg;
        sqx_next       = sqx_reg;
        sqz_next       = sqz_reg;
        dist_next      = dist_reg;
        tag_next       = tag_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg[AW-1:0];
        wr_data        = rd_data;

        case (state_reg)
            dcds_pkg::ST_IDLE: begin
                if (in_req) begin
                    if (s_axis_tuser == dcds_pkg::ACT_START) begin
                        load_cnt_next = '0;
                        eptr_next     = '0;
                        rd_en         = (kept_reg != '0);
                        rd_addr       = '0;
                    end else if (load_cnt_reg < CW'(MAX_OBJECTS)) begin
                        dx_next = DIFF_EXT(s_axis_tdata[15:0]) - DIFF_EXT(cam_x_reg);
                        dz_next = DIFF_EXT(s_axis_tdata[31:16]) - DIFF_EXT(cam_z_reg);
                        tag_next      = dcds_pkg::IDX_W'(load_cnt_reg);
                        load_cnt_next = load_cnt_reg + CW'(1);
                    end
                end
            end
            dcds_pkg::ST_SQUARE: begin
                // squares are non-negative and below 2^32
                sqx_next = prod_x[dcds_pkg::SQ_W-1:0];
                sqz_next = prod_z[dcds_pkg::SQ_W-1:0];
            end
            dcds_pkg::ST_ADD: begin
                dist_next = {1'b0, sqx_reg} + {1'b0, sqz_reg};
            end
            dcds_pkg::ST_CHECK: begin
                if (dist_reg <= max_dist_reg && kept_reg < CW'(MAX_OBJECTS)) begin
                    ptr_next = kept_reg;
                    if (kept_reg != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(kept_reg - CW'(1));
                    end
                end
            end
            dcds_pkg::ST_SHIFT: begin
                // move a strictly nearer entry one slot down, then look above it
                if (rd_data.dsq < dist_reg) begin
                    wr_en    = 1'b1;
                    ptr_next = ptr_reg - CW'(1);
                    if (ptr_reg != CW'(1)) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(ptr_reg - CW'(2));
                    end
                end
            end
            dcds_pkg::ST_PLACE: begin
                wr_en       = 1'b1;
                wr_data.idx = tag_reg;
                wr_data.dsq = dist_reg;
                kept_next   = kept_reg + CW'(1);
            end
            dcds_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_data;
                    out_last_next  = emit_last;
                    out_empty_next = 1'b0;
                    if (emit_last) begin
                        kept_next = '0;
                    end else begin
                        rd_en     = 1'b1;
                        rd_addr   = eptr_reg + AW'(1);
                        eptr_next = eptr_reg + AW'(1);
                    end
                end
            end
            dcds_pkg::ST_EMPTY: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_last_next  = 1'b1;
                    out_empty_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dcds_pkg::ST_IDLE;
            kept_reg      <= '0;
            load_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            kept_reg      <= kept_next;
            load_cnt_reg  <= load_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg       <= ptr_next;
        eptr_reg      <= eptr_next;
        dx_reg        <= dx_next;
        dz_reg        <= dz_next;
        sqx_reg       <= sqx_next;
        sqz_reg       <= sqz_next;
        dist_reg      <= dist_next;
        tag_reg       <= tag_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign s_axis_tready = (state_reg == dcds_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg.dsq, out_data_reg.idx};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_empty_reg;

endmodule
